// ===== rtl/core/color_match_recolor_assert.svh =====
// Assertion macros for the color match recolor checker.
`ifndef COLOR_MATCH_RECOLOR_ASSERT_SVH
`define COLOR_MATCH_RECOLOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CMR_ASSERT_IMPLY(label, clk_i, rstn_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("color_match_recolor: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CMR_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("color_match_recolor: check failed");

`endif

// ===== rtl/core/cmr_pkg.sv =====
// Shared types and constants of the color match recolor block.
package cmr_pkg;

	typedef logic [2:0][7:0] pix_t;

	// Configuration register indexes
	localparam logic [2:0] REG_SRC_RED   = 3'd0;
	localparam logic [2:0] REG_SRC_GREEN = 3'd1;
	localparam logic [2:0] REG_SRC_BLUE  = 3'd2;
	localparam logic [2:0] REG_TGT_RED   = 3'd3;
	localparam logic [2:0] REG_TGT_GREEN = 3'd4;
	localparam logic [2:0] REG_TGT_BLUE  = 3'd5;
	localparam logic [2:0] REG_TOL       = 3'd6;
	localparam logic [2:0] REG_MODE      = 3'd7;

	// Change modes
	localparam logic [1:0] MODE_HUE  = 2'd0;
	localparam logic [1:0] MODE_LUMA = 2'd1;
	localparam logic [1:0] MODE_FULL = 2'd2;

	localparam logic [15:0] LUMA_KR    = 16'd19595;
	localparam logic [15:0] LUMA_KG    = 16'd38470;
	localparam logic [15:0] LUMA_KB    = 16'd7471;
	localparam logic [23:0] LUMA_FLOOR = 24'd16712;
	localparam logic [16:0] ONE_Q16    = 17'd65536;
	localparam logic [15:0] RECIP_255  = 16'h8081;
	localparam logic [9:0]  TOL_SCALE  = 10'd1000;

	localparam int SUM_W  = 18;
	localparam int ROOT_W = 25;
	localparam int REM_W  = 27;
	localparam int RNUM_W = 35;
	localparam int RDEN_W = 18;
	localparam int RQ_W   = 16;
	localparam int SAT_QW = 17;
	localparam int LUMA_W = 24;
	localparam int LQ_W   = 35;

endpackage

// ===== rtl/core/cmr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module cmr_div #(
	parameter int QW = 16,
	parameter int DW = 18
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] rem_in,
	input  logic [QW-1:0] num_in,
	input  logic [DW-1:0] den_in,
	output logic [QW-1:0] quo
);

	logic [DW-1:0] rem_s [0:QW-1];
	logic [QW-1:0] qn_s  [0:QW-1];
	logic [DW-1:0] den_s [0:QW-1];

	generate
		for (genvar k = 0; k < QW; k++) begin : g_stage
			logic [DW-1:0] r_prev;
			logic [DW-1:0] d_prev;
			logic [QW-1:0] q_prev;
			logic [DW:0]   trial;
			logic          ge;

			if (k == 0) begin : g_first
				assign r_prev = rem_in;
				assign q_prev = num_in;
				assign d_prev = den_in;
			end else begin : g_next
				assign r_prev = rem_s[k-1];
				assign q_prev = qn_s[k-1];
				assign d_prev = den_s[k-1];
			end

			// bring down the next numerator bit from the top of the shift word
			assign trial = {r_prev, q_prev[QW-1]};
			assign ge    = trial >= {1'b0, d_prev};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? DW'(trial - {1'b0, d_prev}) : trial[DW-1:0];
					qn_s[k]  <= {q_prev[QW-2:0], ge};
					den_s[k] <= d_prev;
				end
			end
		end
	endgenerate

	assign quo = qn_s[QW-1];

endmodule

// ===== rtl/core/color_match_recolor.sv =====
// Color match recolor: a pixel is accepted every clock while s_tready is high, and its
// result shows on m_tvalid once it has passed the pipeline. The match path is the 25-stage
// square root that forms the color distance followed by the 16-stage ratio divider; the
// hue and luma paths (17- and 35-stage dividers) run alongside. An output register with
// one skid entry keeps the input open while a result waits; s_tready drops only when both
// hold a result. Configuration writes are taken every cycle and must only come while idle.
module color_match_recolor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // in_red [7:0], in_green [15:8], in_blue [23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	typedef logic [2:0][23:0] ta_t;
	typedef logic [2:0][25:0] n0_t;
	typedef logic [2:0][34:0] n_t;

	localparam int SQ_PAIRS = cmr_pkg::SUM_W / 2;
	localparam int LAST     = 48;

	// configuration
	cmr_pkg::pix_t src_q;
	cmr_pkg::pix_t tgt_q;
	logic [9:0]    tol_q;
	logic [1:0]    mode_q;

	// derived from configuration
	logic [10:0]                  tol_p1;
	logic [18:0]                  rden_full;
	logic [cmr_pkg::RDEN_W-1:0]   rden;
	logic [23:0]                  tl_sum;
	logic [23:0]                  tl_den;

	// pipeline control
	logic              en;
	logic [LAST:1]     v_s;
	logic              ov_q;
	logic              skid_full_q;
	logic [23:0]       od_q;
	logic [23:0]       skid_d_q;

	// pipeline payload
	cmr_pkg::pix_t     px_s [1:46];
	cmr_pkg::pix_t     dif;
	logic [7:0]        cmax_c;
	logic [7:0]        cmin_c;
	logic [7:0]        d_c;
	logic [2:0][15:0]  sq_s1;
	logic [7:0]        cmax_s1;
	logic [7:0]        cmin_s1;
	logic [cmr_pkg::SUM_W-1:0] sum_s2;
	logic [7:0]        d_s2;
	logic [7:0]        sden_s2;
	logic [23:0]       luma_s2;
	logic [2:0][15:0]  td_s2;
	logic [2:0][31:0]  rprod;
	logic [2:0][31:0]  tlum_s3;
	ta_t               ta_s [3:19];
	logic [cmr_pkg::SAT_QW-1:0] sat_s19;
	logic [16:0]       sat_inv;
	n0_t               n0_s [20:38];
	logic [2:0][cmr_pkg::LQ_W-1:0] q1_s38;
	n_t                n_s [39:46];
	logic [cmr_pkg::REM_W-1:0]  sq_rem  [0:cmr_pkg::ROOT_W-1];
	logic [cmr_pkg::ROOT_W-1:0] sq_root [0:cmr_pkg::ROOT_W-1];
	logic [cmr_pkg::SUM_W-1:0]  sq_sum  [0:cmr_pkg::ROOT_W-1];
	logic [cmr_pkg::RNUM_W-1:0] rn_s28;
	logic              over_s [29:45];
	logic [cmr_pkg::RDEN_W-1:0] rhi_s29;
	logic [cmr_pkg::RQ_W-1:0]   rlo_s29;
	logic [cmr_pkg::RQ_W-1:0]   ratio_s45;
	logic [16:0]       m_s46;
	logic [16:0]       m_inv;
	logic [2:0][24:0]  pa_s47;
	logic [2:0][51:0]  pb_s47;
	logic [2:0][52:0]  acc;
	cmr_pkg::pix_t     out_c;
	cmr_pkg::pix_t     out_s48;

	// ---------------------------------------------------------------- configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q  <= {8'd0, 8'd0, 8'd255};
			tgt_q  <= {8'd255, 8'd0, 8'd0};
			tol_q  <= 10'd300;
			mode_q <= cmr_pkg::MODE_FULL;
		end else if (cfg_valid) begin
			case (cfg_index)
				cmr_pkg::REG_SRC_RED:   src_q[0] <= cfg_data[7:0];
				cmr_pkg::REG_SRC_GREEN: src_q[1] <= cfg_data[7:0];
				cmr_pkg::REG_SRC_BLUE:  src_q[2] <= cfg_data[7:0];
				cmr_pkg::REG_TGT_RED:   tgt_q[0] <= cfg_data[7:0];
				cmr_pkg::REG_TGT_GREEN: tgt_q[1] <= cfg_data[7:0];
				cmr_pkg::REG_TGT_BLUE:  tgt_q[2] <= cfg_data[7:0];
				cmr_pkg::REG_TOL:       tol_q    <= cfg_data;
				cmr_pkg::REG_MODE:      mode_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// radius divisor 255 * (t + 1), and the target luma held above its floor
	assign tol_p1    = {1'b0, tol_q} + 11'd1;
	assign rden_full = {tol_p1, 8'd0} - {8'd0, tol_p1};
	assign rden      = rden_full[cmr_pkg::RDEN_W-1:0];
	assign tl_sum    = 24'(cmr_pkg::LUMA_KR) * 24'(tgt_q[0])
	                 + 24'(cmr_pkg::LUMA_KG) * 24'(tgt_q[1])
	                 + 24'(cmr_pkg::LUMA_KB) * 24'(tgt_q[2]);
	assign tl_den    = (tl_sum < cmr_pkg::LUMA_FLOOR) ? cmr_pkg::LUMA_FLOOR : tl_sum;

	// ---------------------------------------------------------------- flow control
	assign en       = !skid_full_q;
	assign s_tready = en;
	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s         <= '0;
			ov_q        <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (en) begin
			v_s <= {v_s[LAST-1:1], s_tvalid};
			if (!ov_q || m_tready) begin
				ov_q <= v_s[LAST];
			end else if (v_s[LAST]) begin
				skid_full_q <= 1'b1;
			end
		end else if (m_tready) begin
			skid_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!ov_q || m_tready) begin
				od_q <= out_s48;
			end else begin
				skid_d_q <= out_s48;
			end
		end else if (m_tready) begin
			od_q <= skid_d_q;
		end
	end

	// ---------------------------------------------------------------- front stages
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dif[k] = (s_tdata[8*k +: 8] > src_q[k]) ? s_tdata[8*k +: 8] - src_q[k]
			                                         : src_q[k] - s_tdata[8*k +: 8];
		end
		cmax_c = s_tdata[7:0];
		cmin_c = s_tdata[7:0];
		for (int k = 1; k < 3; k++) begin
			if (s_tdata[8*k +: 8] > cmax_c) begin
				cmax_c = s_tdata[8*k +: 8];
			end
			if (s_tdata[8*k +: 8] < cmin_c) begin
				cmin_c = s_tdata[8*k +: 8];
			end
		end
	end

	assign d_c = cmax_s1 - cmin_s1;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rprod[k] = 32'(td_s2[k]) * 32'(cmr_pkg::RECIP_255);
		end
	end

	assign sat_inv = cmr_pkg::ONE_Q16 - sat_s19;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s[1] <= s_tdata;
			for (int i = 2; i <= 46; i++) begin
				px_s[i] <= px_s[i-1];
			end
			for (int k = 0; k < 3; k++) begin
				sq_s1[k] <= 16'(dif[k]) * 16'(dif[k]);
			end
			cmax_s1 <= cmax_c;
			cmin_s1 <= cmin_c;

			sum_s2  <= 18'(sq_s1[0]) + 18'(sq_s1[1]) + 18'(sq_s1[2]);
			d_s2    <= d_c;
			// a black pixel has no saturation; divide zero by one
			sden_s2 <= (cmax_s1 == 8'd0) ? 8'd1 : cmax_s1;
			luma_s2 <= 24'(cmr_pkg::LUMA_KR) * 24'(px_s[1][0])
			         + 24'(cmr_pkg::LUMA_KG) * 24'(px_s[1][1])
			         + 24'(cmr_pkg::LUMA_KB) * 24'(px_s[1][2]);
			for (int k = 0; k < 3; k++) begin
				td_s2[k] <= 16'(tgt_q[k]) * {8'd0, d_c};
			end

			// x * 65536 / 255 = x * 257 + x / 255
			for (int k = 0; k < 3; k++) begin
				tlum_s3[k]  <= 32'(tgt_q[k]) * 32'(luma_s2);
				ta_s[3][k]  <= 24'({td_s2[k], 8'd0}) + 24'(td_s2[k]) + 24'(rprod[k][31:23]);
			end
			for (int i = 4; i <= 19; i++) begin
				ta_s[i] <= ta_s[i-1];
			end

			for (int k = 0; k < 3; k++) begin
				n0_s[20][k] <= 26'(ta_s[19][k]) + 26'(px_s[19][k]) * 26'(sat_inv);
			end
			for (int i = 21; i <= 38; i++) begin
				n0_s[i] <= n0_s[i-1];
			end

			for (int k = 0; k < 3; k++) begin
				case (mode_q)
					cmr_pkg::MODE_HUE:  n_s[39][k] <= 35'(n0_s[38][k]);
					cmr_pkg::MODE_LUMA: n_s[39][k] <= q1_s38[k];
					default:            n_s[39][k] <= 35'({tgt_q[k], 16'd0});
				endcase
			end
			for (int i = 40; i <= 46; i++) begin
				n_s[i] <= n_s[i-1];
			end
		end
	end

	// ---------------------------------------------------------------- square root
	generate
		for (genvar j = 0; j < cmr_pkg::ROOT_W; j++) begin : g_sqrt
			logic [cmr_pkg::REM_W-1:0]  r_prev;
			logic [cmr_pkg::ROOT_W-1:0] rt_prev;
			logic [cmr_pkg::SUM_W-1:0]  sm_prev;
			logic [1:0]                 pair;
			logic [cmr_pkg::REM_W+1:0]  tv;
			logic [cmr_pkg::REM_W+1:0]  trial;
			logic                       ge;

			if (j == 0) begin : g_first
				assign r_prev  = '0;
				assign rt_prev = '0;
				assign sm_prev = sum_s2;
			end else begin : g_next
				assign r_prev  = sq_rem[j-1];
				assign rt_prev = sq_root[j-1];
				assign sm_prev = sq_sum[j-1];
			end

			// the low 32 radicand bits are zero
			if (j < SQ_PAIRS) begin : g_pair
				assign pair = sm_prev[cmr_pkg::SUM_W-1-2*j -: 2];
			end else begin : g_zero
				assign pair = 2'b00;
			end

			assign tv    = {r_prev, pair};
			assign trial = {2'b00, rt_prev, 2'b01};
			assign ge    = tv >= trial;

			always_ff @(posedge clk) begin
				if (en) begin
					sq_rem[j]  <= ge ? cmr_pkg::REM_W'(tv - trial) : tv[cmr_pkg::REM_W-1:0];
					sq_root[j] <= {rt_prev[cmr_pkg::ROOT_W-2:0], ge};
					sq_sum[j]  <= sm_prev;
				end
			end
		end
	endgenerate

	// ---------------------------------------------------------------- dividers
	cmr_div #(
		.QW (cmr_pkg::SAT_QW),
		.DW (8)
	) u_sat_div (
		.clk    (clk),
		.en     (en),
		.rem_in ({1'b0, d_s2[7:1]}),
		.num_in ({d_s2[0], 16'd0}),
		.den_in (sden_s2),
		.quo    (sat_s19)
	);

	generate
		for (genvar k = 0; k < 3; k++) begin : g_luma_div
			cmr_div #(
				.QW (cmr_pkg::LQ_W),
				.DW (cmr_pkg::LUMA_W)
			) u_luma_div (
				.clk    (clk),
				.en     (en),
				.rem_in ({11'd0, tlum_s3[k][31:19]}),
				.num_in ({tlum_s3[k][18:0], 16'd0}),
				.den_in (tl_den),
				.quo    (q1_s38[k])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			rn_s28    <= 35'(sq_root[cmr_pkg::ROOT_W-1]) * 35'(cmr_pkg::TOL_SCALE);
			// a ratio of one or more gives no match; skip the divide
			over_s[29] <= rn_s28 >= {1'b0, rden, 16'd0};
			rhi_s29   <= (rn_s28 >= {1'b0, rden, 16'd0}) ? '0 : rn_s28[33:16];
			rlo_s29   <= rn_s28[15:0];
			for (int i = 30; i <= 45; i++) begin
				over_s[i] <= over_s[i-1];
			end
		end
	end

	cmr_div #(
		.QW (cmr_pkg::RQ_W),
		.DW (cmr_pkg::RDEN_W)
	) u_ratio_div (
		.clk    (clk),
		.en     (en),
		.rem_in (rhi_s29),
		.num_in (rlo_s29),
		.den_in (rden),
		.quo    (ratio_s45)
	);

	// ---------------------------------------------------------------- blend
	assign m_inv = cmr_pkg::ONE_Q16 - m_s46;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc[k]   = 53'({pa_s47[k], 16'd0}) + 53'(pb_s47[k]);
			out_c[k] = (|acc[k][52:40]) ? 8'd255 : acc[k][39:32];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s46 <= over_s[45] ? 17'd0 : cmr_pkg::ONE_Q16 - {1'b0, ratio_s45};
			for (int k = 0; k < 3; k++) begin
				pa_s47[k] <= 25'(px_s[46][k]) * 25'(m_inv);
				pb_s47[k] <= 52'(n_s[46][k]) * 52'(m_s46);
			end
			out_s48 <= out_c;
		end
	end

endmodule

// ===== rtl/core/cmr_check.sv =====
// Port-level checker for the color match recolor block, with its bind.
`include "color_match_recolor_assert.svh"

module cmr_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	localparam logic [6:0] CAP = 7'd50;

	logic       in_acc;
	logic       out_acc;
	logic [6:0] cnt_q;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// requests accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else begin
			cnt_q <= cnt_q + 7'(in_acc) - 7'(out_acc);
		end
	end

	`CMR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`CMR_ASSERT_IMPLY(a_no_spurious, clk, arst_n, m_tvalid, cnt_q != 7'd0)
	`CMR_ASSERT_IMPLY(a_capacity, clk, arst_n, 1'b1, cnt_q <= CAP)
	`CMR_ASSERT_IMPLY(a_stall_cause, clk, arst_n, !s_tready, m_tvalid)

endmodule

bind color_match_recolor cmr_check u_cmr_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
